/* hw/rtl/bq_df2_pkg.sv */
// types, constants and microprogram for the direct form II biquad
package bq_df2_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_W         = 24;
    localparam int STATE_FRAC     = 8;
    localparam int STATE_W        = SAMPLE_W + STATE_FRAC;
    localparam int PROD_W         = COEF_W + STATE_W;
    localparam int RND_W          = PROD_W - COEF_FRAC_BITS;
    localparam int ACC_W          = ((RND_W > STATE_W) ? RND_W : STATE_W) + 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = COEF_W;
    localparam int STEP_W         = 3;

    // b0 resets to 1.0, or to the largest coefficient when 1.0 does not fit
    localparam logic signed [COEF_W-1:0] B0_RESET =
        (COEF_FRAC_BITS >= COEF_W - 1) ? {1'b0, {(COEF_W-1){1'b1}}}
                                       : COEF_W'(64'd1 << COEF_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_B0     = 3'd1,
        REG_B1     = 3'd2,
        REG_B2     = 3'd3,
        REG_A1     = 3'd4,
        REG_A2     = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CS_B0 = 3'd0,
        CS_B1 = 3'd1,
        CS_B2 = 3'd2,
        CS_A1 = 3'd3,
        CS_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic [1:0] {
        SS_Z1 = 2'd0,
        SS_Z2 = 2'd1,
        SS_W  = 2'd2
    } state_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_LOAD_X = 3'd1,
        ACC_SUB    = 3'd2,
        ACC_ADD    = 3'd3,
        ACC_CLEAR  = 3'd4
    } acc_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT     = 2'd0,
        SEQ_WAIT_IN  = 2'd1,
        SEQ_WAIT_OUT = 2'd2
    } seq_t;

    typedef struct packed {
        coef_sel_t  coef_sel;
        state_sel_t state_sel;
        logic       mul_en;
        acc_op_t    acc_op;
        logic       w_load;
        logic       out_load;
        seq_t       seq;
    } uword_t;

    // microprogram: a product registered in step k is accumulated in step k+1
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t uw;
        uw = '{CS_B0, SS_Z1, 1'b0, ACC_HOLD, 1'b0, 1'b0, SEQ_NEXT};
        case (step)
            3'd0: uw = '{CS_A2, SS_Z2, 1'b1, ACC_LOAD_X, 1'b0, 1'b0, SEQ_WAIT_IN};
            3'd1: uw = '{CS_A1, SS_Z1, 1'b1, ACC_SUB,    1'b0, 1'b0, SEQ_NEXT};
            3'd2: uw = '{CS_B0, SS_Z1, 1'b0, ACC_SUB,    1'b0, 1'b0, SEQ_NEXT};
            3'd3: uw = '{CS_B2, SS_Z2, 1'b1, ACC_CLEAR,  1'b1, 1'b0, SEQ_NEXT};
            3'd4: uw = '{CS_B1, SS_Z1, 1'b1, ACC_ADD,    1'b0, 1'b0, SEQ_NEXT};
            3'd5: uw = '{CS_B0, SS_W,  1'b1, ACC_ADD,    1'b0, 1'b0, SEQ_NEXT};
            3'd6: uw = '{CS_B0, SS_Z1, 1'b0, ACC_ADD,    1'b0, 1'b0, SEQ_NEXT};
            3'd7: uw = '{CS_B0, SS_Z1, 1'b0, ACC_HOLD,   1'b0, 1'b1, SEQ_WAIT_OUT};
            default: uw = '{CS_B0, SS_Z1, 1'b0, ACC_HOLD, 1'b0, 1'b0, SEQ_NEXT};
        endcase
        return uw;
    endfunction

endpackage

/* hw/rtl/biquad_direct_form_two_filter.sv */
// direct form II biquad: microcoded sequencer around one shared multiplier-accumulator
// filtered beat: result registered in the last step of the 8-step microprogram
// that runs all five products through the one multiplier, one beat at a time
// bypassed beat: result registered at the input beat; one beat per cycle unless stalled
// reset: bypass on, b0 = 1.0, other coefficients 0, delay line cleared, output empty
module biquad_direct_form_two_filter (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         sample_valid,
    output logic                                         sample_stall,
    input  logic signed [bq_df2_pkg::SAMPLE_W-1:0]       sample_in,
    output logic                                         result_valid,
    input  logic                                         result_stall,
    output logic signed [bq_df2_pkg::SAMPLE_W-1:0]       sample_out,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic        [bq_df2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic        [bq_df2_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bq_df2_pkg::*;

    localparam logic signed [PROD_W-1:0] RND_HALF =
        {{(PROD_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] OUT_HALF =
        {{(ACC_W-STATE_FRAC){1'b0}}, 1'b1, {(STATE_FRAC-1){1'b0}}};
    localparam int YSH_W = ACC_W - STATE_FRAC;

    logic                       enable_reg;
    logic signed [COEF_W-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [STATE_W-1:0]  z1_reg, z2_reg, w_reg, w_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_rnd_full;
    logic signed [ACC_W-1:0]    acc_reg, acc_next, rnd_ext, y_sum;
    logic signed [YSH_W-1:0]    y_shift;
    logic signed [SAMPLE_W-1:0] y_sat, out_reg;
    logic        [STEP_W-1:0]   step_reg, step_next;
    logic                       valid_reg;
    logic signed [COEF_W-1:0]   coef_mux;
    logic signed [STATE_W-1:0]  state_mux;
    logic signed [RND_W-1:0]    rnd;
    uword_t                     uw;
    logic                       out_free, beat, go, bypass;

    assign uw           = ucode(step_reg);
    assign cfg_ready    = 1'b1;
    assign out_free     = !valid_reg || !result_stall;
    assign sample_stall = !((uw.seq == SEQ_WAIT_IN) && (enable_reg || out_free));
    assign beat         = sample_valid && !sample_stall;
    assign bypass       = beat && !enable_reg;
    assign result_valid = valid_reg;
    assign sample_out   = out_reg;

    always_comb
    begin
        case (uw.seq)
            SEQ_WAIT_IN:  go = beat && enable_reg;
            SEQ_WAIT_OUT: go = out_free;
            default:      go = 1'b1;
        endcase
        step_next = step_reg;
        if (go)
        begin
            if (uw.seq == SEQ_WAIT_OUT)
                step_next = '0;
            else
                step_next = step_reg + 1'b1;
        end
    end

    // operand selection
    always_comb
    begin
        case (uw.coef_sel)
            CS_B0:   coef_mux = b0_reg;
            CS_B1:   coef_mux = b1_reg;
            CS_B2:   coef_mux = b2_reg;
            CS_A1:   coef_mux = a1_reg;
            CS_A2:   coef_mux = a2_reg;
            default: coef_mux = b0_reg;
        endcase
        case (uw.state_sel)
            SS_Z1:   state_mux = z1_reg;
            SS_Z2:   state_mux = z2_reg;
            SS_W:    state_mux = w_reg;
            default: state_mux = z1_reg;
        endcase
    end

    // round to the state format, then accumulate
    always_comb
    begin
        prod_rnd_full = prod_reg + RND_HALF;
        rnd           = prod_rnd_full[PROD_W-1:COEF_FRAC_BITS];
        rnd_ext       = ACC_W'(rnd);
        case (uw.acc_op)
            ACC_LOAD_X: acc_next = ACC_W'($signed({sample_in, {STATE_FRAC{1'b0}}}));
            ACC_SUB:    acc_next = acc_reg - rnd_ext;
            ACC_ADD:    acc_next = acc_reg + rnd_ext;
            ACC_CLEAR:  acc_next = '0;
            default:    acc_next = acc_reg;
        endcase
    end

    // saturation of w and of the output sample
    always_comb
    begin
        if (acc_reg[ACC_W-1:STATE_W-1] == '0 || acc_reg[ACC_W-1:STATE_W-1] == '1)
            w_next = acc_reg[STATE_W-1:0];
        else
            w_next = {acc_reg[ACC_W-1], {(STATE_W-1){~acc_reg[ACC_W-1]}}};
        y_sum   = acc_reg + OUT_HALF;
        y_shift = y_sum[ACC_W-1:STATE_FRAC];
        if (y_shift[YSH_W-1:SAMPLE_W-1] == '0 || y_shift[YSH_W-1:SAMPLE_W-1] == '1)
            y_sat = y_shift[SAMPLE_W-1:0];
        else
            y_sat = {y_shift[YSH_W-1], {(SAMPLE_W-1){~y_shift[YSH_W-1]}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            b0_reg     <= B0_RESET;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_B0:     b0_reg     <= cfg_data;
                REG_B1:     b1_reg     <= cfg_data;
                REG_B2:     b2_reg     <= cfg_data;
                REG_A1:     a1_reg     <= cfg_data;
                REG_A2:     a2_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
            z1_reg    <= '0;
            z2_reg    <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (bypass || (go && uw.out_load))
                valid_reg <= 1'b1;
            else if (!result_stall)
                valid_reg <= 1'b0;
            // delay line shifts when the result is committed
            if (go && uw.out_load)
            begin
                z2_reg <= z1_reg;
                z1_reg <= w_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && uw.mul_en)
            prod_reg <= coef_mux * state_mux;
        if (go)
            acc_reg <= acc_next;
        if (go && uw.w_load)
            w_reg <= w_next;
        if (bypass)
            out_reg <= sample_in;
        else if (go && uw.out_load)
            out_reg <= y_sat;
    end

endmodule
